// ===== sv/ihw_pkg.sv =====
// Shared types and constants for the integral histogram window query block.
// This file has no dependencies. ihw_front, ihw_back and the top level import it.
package ihw_pkg;

  // Default sizes, used by the top level's parameters.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_BINS   = 16;

  // Register values right after reset. They are clamped to the maxima.
  localparam int RESET_IMG_WIDTH  = 64;
  localparam int RESET_IMG_HEIGHT = 64;
  localparam int RESET_BINS       = 16;

  // Fixed field widths of the external items.
  localparam int PIX_W      = 8;
  localparam int QCOORD_W   = 6;
  localparam int OBIN_W     = 4;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int BINS_CFG_W = 5;

  // Widths inside the command. They cover the full parameter ranges.
  localparam int COORD_W  = 10;
  localparam int BINSEL_W = 6;
  localparam int NBINS_W  = 7;
  localparam int AREA_W   = 21;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

  // Request type codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [PIX_W-1:0]    pixel;
    logic [QCOORD_W-1:0] query_top;
    logic [QCOORD_W-1:0] query_left;
    logic [QCOORD_W-1:0] query_bottom;
    logic [QCOORD_W-1:0] query_right;
  } in_item_t;

  typedef struct packed {
    logic [OBIN_W-1:0] bin_index;
    logic [FRAC_W-1:0] fraction;
    logic              bad_window;
    logic              last;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic                is_query;
    logic                bad;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [BINSEL_W-1:0] bin;
    logic [COORD_W-1:0]  top;
    logic [COORD_W-1:0]  left;
    logic [COORD_W-1:0]  bottom;
    logic [COORD_W-1:0]  right;
    logic [AREA_W-1:0]   area;
    logic [NBINS_W-1:0]  nbins;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_QUERY,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== sv/ihw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module ihw_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ihw_fifo.sv =====
// Small first-in first-out queue of plain bit vectors.
// Depends on nothing; used for the command queue and the result queue.
module ihw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? AW'(wp_r + AW'(1)) : wp_r;
    rp_nxt  = do_pop ? AW'(rp_r + AW'(1)) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== sv/ihw_front.sv =====
// Front end: configuration registers, load position tracking and classification
// of input items into commands. Depends on ihw_pkg.
module ihw_front #(
  parameter int MAX_WIDTH  = ihw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ihw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BINS   = ihw_pkg::DEF_MAX_BINS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ihw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ihw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_push,
  input  ihw_pkg::in_item_t               in_item,
  input  logic                            cmd_full,
  output logic                            cmd_push,
  output ihw_pkg::cmd_t                   cmd
);
  import ihw_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int NBW = $clog2(MAX_BINS + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RST_W = (RESET_IMG_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_IMG_WIDTH;
  localparam int RST_H = (RESET_IMG_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_IMG_HEIGHT;
  localparam int RST_B = (RESET_BINS > MAX_BINS) ? MAX_BINS : RESET_BINS;

  logic [WW-1:0]  width_r, width_nxt;
  logic [HW-1:0]  height_r, height_nxt;
  logic [NBW-1:0] bins_r, bins_nxt;
  logic [RW-1:0]  row_r, row_nxt, cur_row;
  logic [CW-1:0]  col_r, col_nxt, cur_col;
  logic           loaded_r, loaded_nxt;

  logic                    accept, is_load;
  logic [COORD_W:0]        col_inc, row_inc;
  logic                    wrap_col, wrap_row;
  logic [PIX_W+NBW-1:0]    bin_prod;
  logic [QCOORD_W:0]       win_h, win_w;
  logic [2*QCOORD_W+1:0]   win_area;
  logic                    bad;

  assign accept   = in_push && !cmd_full;
  assign cmd_push = accept;
  assign is_load  = (in_item.req_type == REQ_LOAD);

  // A completed image is followed by a fresh one starting at the origin.
  assign cur_row  = loaded_r ? '0 : row_r;
  assign cur_col  = loaded_r ? '0 : col_r;
  assign col_inc  = (COORD_W+1)'(cur_col) + (COORD_W+1)'(1);
  assign row_inc  = (COORD_W+1)'(cur_row) + (COORD_W+1)'(1);
  assign wrap_col = (col_inc >= (COORD_W+1)'(width_r));
  assign wrap_row = (row_inc >= (COORD_W+1)'(height_r));
  assign bin_prod = (PIX_W+NBW)'(in_item.pixel) * (PIX_W+NBW)'(bins_r);

  assign win_h    = (QCOORD_W+1)'(in_item.query_bottom) - (QCOORD_W+1)'(in_item.query_top)
                    + (QCOORD_W+1)'(1);
  assign win_w    = (QCOORD_W+1)'(in_item.query_right) - (QCOORD_W+1)'(in_item.query_left)
                    + (QCOORD_W+1)'(1);
  assign win_area = (2*QCOORD_W+2)'(win_h) * (2*QCOORD_W+2)'(win_w);

  assign bad = !loaded_r
            || (in_item.query_top > in_item.query_bottom)
            || (in_item.query_left > in_item.query_right)
            || ((COORD_W+1)'(in_item.query_bottom) >= (COORD_W+1)'(height_r))
            || ((COORD_W+1)'(in_item.query_right) >= (COORD_W+1)'(width_r));

  always_comb begin
    cmd.is_query = !is_load;
    cmd.bad      = bad;
    cmd.row      = COORD_W'(cur_row);
    cmd.col      = COORD_W'(cur_col);
    cmd.bin      = BINSEL_W'(bin_prod >> PIX_W);
    cmd.top      = COORD_W'(in_item.query_top);
    cmd.left     = COORD_W'(in_item.query_left);
    cmd.bottom   = COORD_W'(in_item.query_bottom);
    cmd.right    = COORD_W'(in_item.query_right);
    cmd.area     = AREA_W'(win_area);
    cmd.nbins    = NBINS_W'(bins_r);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    bins_nxt   = bins_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    loaded_nxt = loaded_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMG_WIDTH: begin
          width_nxt = (cfg_wdata == '0) ? WW'(1) :
                      ((int'(cfg_wdata) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_wdata));
        end
        REG_IMG_HEIGHT: begin
          height_nxt = (cfg_wdata == '0) ? HW'(1) :
                       ((int'(cfg_wdata) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata));
        end
        REG_BINS_IN_USE: begin
          bins_nxt = (cfg_wdata[BINS_CFG_W-1:0] == '0) ? NBW'(1) :
                     ((int'(cfg_wdata[BINS_CFG_W-1:0]) > MAX_BINS) ? NBW'(MAX_BINS) :
                      NBW'(cfg_wdata[BINS_CFG_W-1:0]));
        end
        default: ;
      endcase
      // Any write to a real register restarts loading.
      if (cfg_index == REG_IMG_WIDTH || cfg_index == REG_IMG_HEIGHT ||
          cfg_index == REG_BINS_IN_USE) begin
        row_nxt    = '0;
        col_nxt    = '0;
        loaded_nxt = 1'b0;
      end
    end else if (accept && is_load) begin
      loaded_nxt = 1'b0;
      if (!wrap_col) begin
        col_nxt = CW'(col_inc);
        row_nxt = cur_row;
      end else begin
        col_nxt = '0;
        if (!wrap_row) begin
          row_nxt = RW'(row_inc);
        end else begin
          row_nxt    = '0;
          loaded_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= HW'(RST_H);
      bins_r   <= NBW'(RST_B);
      row_r    <= '0;
      col_r    <= '0;
      loaded_r <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bins_r   <= bins_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      loaded_r <= loaded_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    ((COORD_W+1)'(col_r) < (COORD_W+1)'(width_r)) &&
    ((COORD_W+1)'(row_r) < (COORD_W+1)'(height_r)))
    else $error("load position outside the configured image");
  a_loaded_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r |-> (row_r == '0 && col_r == '0))
    else $error("image marked loaded with a nonzero load position");
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_BINS_IN_USE) |=> !loaded_r)
    else $error("register write did not restart loading");
`endif

endmodule

// ===== sv/ihw_back.sv =====
// Back end: executes load and query commands against the count memory and
// divides window counts by the window area. Depends on ihw_pkg, ihw_ram.
module ihw_back #(
  parameter int MAX_WIDTH  = ihw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ihw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BINS   = ihw_pkg::DEF_MAX_BINS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  ihw_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output ihw_pkg::out_item_t res
);
  import ihw_pkg::*;

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int BW    = $clog2(MAX_BINS);
  localparam int AW    = RW + CW + BW;
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DVD_W = CNT_W + FRAC_SHIFT;
  localparam int DC_W  = $clog2(DVD_W + 1);
  localparam logic [2:0] STEP_LOAD_LAST  = 3'd3;
  localparam logic [2:0] STEP_QUERY_LAST = 3'd4;

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [BW-1:0]     bin_r, bin_nxt;
  logic [CNT_W:0]    acc_r, acc_nxt;
  logic              use_r, use_nxt;
  logic [AREA_W-1:0] rem_r, rem_nxt;
  logic [FRAC_W-1:0] quo_r, quo_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DC_W-1:0]   dcnt_r, dcnt_nxt;

  logic [COORD_W-1:0] rd_row, rd_col;
  logic               rd_use;
  logic [AW-1:0]      raddr, waddr;
  logic               ram_we;
  logic [CNT_W-1:0]   wdata, rdata;
  logic [CNT_W:0]     val, hit, cnt;
  logic               last_bin;
  logic [AREA_W:0]    rem_sh;
  logic               ge;

  assign last_bin = ((NBINS_W'(bin_r) + NBINS_W'(1)) == cmd_r.nbins);
  assign val      = use_r ? (CNT_W+1)'(rdata) : '0;
  assign hit      = (BINSEL_W'(bin_r) == cmd_r.bin) ? (CNT_W+1)'(1) : '0;
  assign cnt      = acc_r - val;
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign ge       = (rem_sh >= (AREA_W+1)'(cmd_r.area));

  // Neighbor selection for the read issued in the current step.
  always_comb begin
    rd_row = cmd_r.row;
    rd_col = cmd_r.col;
    rd_use = 1'b0;
    if (!cmd_r.is_query) begin
      case (step_r)
        3'd0: begin
          rd_row = cmd_r.row - COORD_W'(1);
          rd_use = (cmd_r.row != '0);
        end
        3'd1: begin
          rd_col = cmd_r.col - COORD_W'(1);
          rd_use = (cmd_r.col != '0);
        end
        3'd2: begin
          rd_row = cmd_r.row - COORD_W'(1);
          rd_col = cmd_r.col - COORD_W'(1);
          rd_use = (cmd_r.row != '0) && (cmd_r.col != '0);
        end
        default: ;
      endcase
    end else begin
      rd_row = cmd_r.bottom;
      rd_col = cmd_r.right;
      case (step_r)
        3'd0: rd_use = 1'b1;
        3'd1: begin
          rd_row = cmd_r.top - COORD_W'(1);
          rd_col = cmd_r.left - COORD_W'(1);
          rd_use = (cmd_r.top != '0) && (cmd_r.left != '0);
        end
        3'd2: begin
          rd_col = cmd_r.left - COORD_W'(1);
          rd_use = (cmd_r.left != '0);
        end
        3'd3: begin
          rd_row = cmd_r.top - COORD_W'(1);
          rd_use = (cmd_r.top != '0);
        end
        default: ;
      endcase
    end
  end

  assign raddr = {rd_row[RW-1:0], rd_col[CW-1:0], bin_r};
  assign waddr = {cmd_r.row[RW-1:0], cmd_r.col[CW-1:0], bin_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = !cmd.is_query ? BK_LOAD : (cmd.bad ? BK_EMIT : BK_QUERY);
        end
      end
      BK_LOAD: begin
        if (step_r == STEP_LOAD_LAST && last_bin) state_nxt = BK_IDLE;
      end
      BK_QUERY: begin
        if (step_r == STEP_QUERY_LAST) state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (dcnt_r == DC_W'(1)) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (!res_full) begin
          state_nxt = last_bin ? BK_IDLE : (cmd_r.bad ? BK_EMIT : BK_QUERY);
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    ram_we   = 1'b0;
    wdata    = CNT_W'(acc_r - val + hit);
    cmd_nxt  = cmd_r;
    step_nxt = step_r;
    bin_nxt  = bin_r;
    acc_nxt  = acc_r;
    use_nxt  = use_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvd_nxt  = dvd_r;
    dcnt_nxt = dcnt_r;
    res.bin_index  = OBIN_W'(bin_r);
    res.fraction   = cmd_r.bad ? '0 : quo_r;
    res.bad_window = cmd_r.bad;
    res.last       = last_bin;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd;
          bin_nxt  = '0;
          step_nxt = '0;
        end
      end
      BK_LOAD: begin
        use_nxt  = rd_use;
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1: acc_nxt = val;
          3'd2: acc_nxt = acc_r + val;
          3'd3: begin
            ram_we   = 1'b1;
            step_nxt = '0;
            bin_nxt  = bin_r + BW'(1);
          end
          default: ;
        endcase
      end
      BK_QUERY: begin
        use_nxt  = rd_use;
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1: acc_nxt = val;
          3'd2: acc_nxt = acc_r + val;
          3'd3: acc_nxt = acc_r - val;
          3'd4: begin
            dvd_nxt  = {CNT_W'(cnt), FRAC_SHIFT'(0)};
            rem_nxt  = '0;
            quo_nxt  = '0;
            dcnt_nxt = DC_W'(DVD_W);
            step_nxt = '0;
          end
          default: ;
        endcase
      end
      BK_DIV: begin
        rem_nxt  = ge ? AREA_W'(rem_sh - (AREA_W+1)'(cmd_r.area)) : rem_sh[AREA_W-1:0];
        quo_nxt  = {quo_r[FRAC_W-2:0], ge};
        dvd_nxt  = dvd_r << 1;
        dcnt_nxt = dcnt_r - DC_W'(1);
      end
      BK_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          bin_nxt  = bin_r + BW'(1);
          step_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= '0;
      bin_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      bin_r   <= bin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    acc_r  <= acc_nxt;
    use_r  <= use_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvd_r  <= dvd_nxt;
    dcnt_r <= dcnt_nxt;
  end

  ihw_ram #(
    .WIDTH (CNT_W),
    .DEPTH (1 << AW)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  a_write_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == BK_LOAD))
    else $error("count memory written outside a load");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == BK_IDLE && !cmd_empty))
    else $error("command taken while busy");
  a_push_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (state_r == BK_EMIT && !res_full))
    else $error("result pushed outside the emit state");
  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> (NBINS_W'(bin_r) < cmd_r.nbins))
    else $error("bin counter beyond the bins in use");
`endif

endmodule

// ===== sv/integral_histogram_window_query.sv =====
// Load item: for each bin in use, the three neighbor sums are read and the new sum is written,
// one bin after another. Query item: for each bin, four corner sums are read from memory, the
// window count is divided by the area in the bit-serial divider and one result is emitted;
// the pace is set by the single count memory read port and the bit-serial divider.
// Reset (rst_n, synchronous, active low) clears the queues, the sequencer, the load
// position and sets registers to their defaults; the count memory is not cleared.
module integral_histogram_window_query #(
  parameter int MAX_WIDTH  = ihw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ihw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BINS   = ihw_pkg::DEF_MAX_BINS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ihw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ihw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_push,
  input  ihw_pkg::in_item_t              in_item,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output ihw_pkg::out_item_t             out_item
);
  import ihw_pkg::*;

  // The front end classifies each item into a command. Loads carry their pixel
  // position and bin; queries carry the window, its area and a bad flag that
  // reflects the image state at the moment the item was taken.
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  // The back end pushes finished results into a small queue, so a stalled
  // consumer only blocks the back end once that queue fills.
  logic      res_push, res_full;
  out_item_t res;

  assign in_full = cmd_full;

  ihw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BINS   (MAX_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  ihw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  ihw_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BINS   (MAX_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  ihw_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule

// ===== dv/ihw_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for integral_histogram_window_query: watches the configuration port and both
// item channels, keeps its own integral histogram and compares every result it sees.
// Depends on ihw_pkg for the item types, register indexes and request codes.
module ihw_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_push,
  input  ihw_pkg::in_item_t  in_item,
  input  logic               in_full,
  input  logic               out_empty,
  input  logic               out_pop,
  input  ihw_pkg::out_item_t out_item,
  output int                 pending,
  output int                 fail_count
);
  import ihw_pkg::*;

  localparam int WMAX = DEF_MAX_WIDTH;
  localparam int HMAX = DEF_MAX_HEIGHT;
  localparam int BMAX = DEF_MAX_BINS;

  int unsigned hist_sum [WMAX*HMAX*BMAX];
  int unsigned width_now, height_now, bins_now, next_row, next_col;
  bit          image_full;
  out_item_t   bin_share_q[$];

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned sum_at(int unsigned r, int unsigned c, int unsigned h);
    return hist_sum[(r*WMAX + c)*BMAX + h];
  endfunction

  task automatic restart_image();
    next_row = 0;
    next_col = 0;
    image_full = 0;
  endtask

  task automatic add_pixel(logic [7:0] pix);
    int unsigned r, c, b, up, lf, dg;
    if (image_full) restart_image();
    r = next_row;
    c = next_col;
    b = (pix * bins_now) >> 8;
    for (int unsigned h = 0; h < bins_now; h++) begin
      up = (r > 0) ? sum_at(r-1, c, h) : 0;
      lf = (c > 0) ? sum_at(r, c-1, h) : 0;
      dg = (r > 0 && c > 0) ? sum_at(r-1, c-1, h) : 0;
      hist_sum[(r*WMAX + c)*BMAX + h] = up + lf - dg + ((h == b) ? 1 : 0);
    end
    if (c + 1 < width_now) begin
      next_col = c + 1;
    end else begin
      next_col = 0;
      if (r + 1 < height_now) begin
        next_row = r + 1;
      end else begin
        next_row = 0;
        image_full = 1;
      end
    end
  endtask

  task automatic window_shares(in_item_t it);
    int unsigned t, l, b, r, area, cnt;
    bit          bad;
    longint unsigned frac;
    out_item_t   res;
    t = it.query_top;
    l = it.query_left;
    b = it.query_bottom;
    r = it.query_right;
    bad = !image_full || t > b || l > r || b >= height_now || r >= width_now;
    area = bad ? 1 : (b - t + 1) * (r - l + 1);
    for (int unsigned h = 0; h < bins_now; h++) begin
      frac = 0;
      if (!bad) begin
        cnt = sum_at(b, r, h) + ((t > 0 && l > 0) ? sum_at(t-1, l-1, h) : 0)
              - ((l > 0) ? sum_at(b, l-1, h) : 0) - ((t > 0) ? sum_at(t-1, r, h) : 0);
        frac = (longint'(cnt) << 16) / area;
      end
      res.bin_index  = h[3:0];
      res.fraction   = frac[16:0];
      res.bad_window = bad;
      res.last       = (h + 1 == bins_now);
      bin_share_q.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      width_now  = clamp_reg(RESET_IMG_WIDTH, WMAX);
      height_now = clamp_reg(RESET_IMG_HEIGHT, HMAX);
      bins_now   = clamp_reg(RESET_BINS, BMAX);
      restart_image();
      bin_share_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMG_WIDTH: begin
            width_now = clamp_reg(cfg_wdata, WMAX);
            restart_image();
          end
          REG_IMG_HEIGHT: begin
            height_now = clamp_reg(cfg_wdata, HMAX);
            restart_image();
          end
          REG_BINS_IN_USE: begin
            bins_now = clamp_reg(cfg_wdata & 7'h1F, BMAX);
            restart_image();
          end
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (bin_share_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: bin %0d frac %0d bad %0b last %0b",
                     out_item.bin_index, out_item.fraction, out_item.bad_window,
                     out_item.last);
        end else begin
          want = bin_share_q.pop_front();
          if (want.bin_index !== out_item.bin_index || want.fraction !== out_item.fraction ||
              want.bad_window !== out_item.bad_window || want.last !== out_item.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected bin %0d frac %0d bad %0b last %0b, got bin %0d frac %0d bad %0b last %0b",
                       want.bin_index, want.fraction, want.bad_window, want.last,
                       out_item.bin_index, out_item.fraction, out_item.bad_window,
                       out_item.last);
          end
        end
      end
      if (in_push && !in_full) begin
        if (in_item.req_type == REQ_LOAD) add_pixel(in_item.pixel);
        else window_shares(in_item);
      end
    end
    pending = bin_share_q.size();
  end

  // Results still owed at the end of the run are failures.
  function automatic int leftover();
    return bin_share_q.size();
  endfunction

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the integral_histogram_window_query regression: clock, reset, stimulus, the
// receiver, a watchdog and the verdict. Depends on ihw_pkg, the block and ihw_checker.
module testbench;
  import ihw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_WAIT     = 300;
  localparam int ITEM_TARGET    = 270;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;
  logic      in_push = 0;
  in_item_t  in_item = '0;
  logic      in_full, out_empty;
  logic      out_pop = 0;
  out_item_t out_item;
  int        pending, fail_count;

  // Stimulus and receiver share these: calm switches all idling off for the last part,
  // and a long hold is asked for by bumping hold_asked.
  bit calm = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  integral_histogram_window_query dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_item, .in_full, .out_empty, .out_pop, .out_item
  );

  ihw_checker scoreboard (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_item, .in_full, .out_empty, .out_pop, .out_item,
    .pending, .fail_count
  );

  // The receiver idles in short random bursts, or for one long stretch when asked,
  // so that the block's result queue fills and it has to push back on its input.
  int rx_idle = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
    end else if (hold_given != hold_asked) begin
      hold_given = hold_asked;
      rx_idle = LONG_HOLD;
      out_pop <= 0;
    end else if (rx_idle > 0) begin
      rx_idle--;
      out_pop <= 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_idle = $urandom_range(0, 10);
      out_pop <= 0;
    end else begin
      out_pop <= 1;
    end
  end

  // The watchdog counts cycles without any handshake or register write.
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("integral_histogram_window_query regression: fail");
        $finish;
      end
    end
  end

  function automatic int unsigned effective(int unsigned v);
    return (v == 0) ? 1 : ((v > 64) ? 64 : v);
  endfunction

  // Called at a falling edge; returns at a falling edge after the item was taken.
  // push stays high into the next item unless a random gap drops it.
  task automatic send(in_item_t it);
    in_item <= it;
    in_push <= 1;
    do @(posedge clk); while (in_full);
    items_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task automatic load_pixel(logic [7:0] pix);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.req_type = REQ_LOAD;
    it.pixel = pix;
    send(it);
  endtask

  task automatic query(int unsigned t, int unsigned l, int unsigned b, int unsigned r);
    in_item_t it;
    it.req_type     = REQ_QUERY;
    it.pixel        = 8'($urandom_range(0, 255));
    it.query_top    = t[5:0];
    it.query_left   = l[5:0];
    it.query_bottom = b[5:0];
    it.query_right  = r[5:0];
    send(it);
  endtask

  // Most phases end on a query, so once its results are in all earlier loads are done;
  // the extra wait covers anything still in flight inside the block.
  task automatic drain();
    in_push <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic load_image(int unsigned n);
    repeat (n) load_pixel(8'($urandom_range(0, 255)));
  endtask

  task automatic random_window(int unsigned w, int unsigned h);
    int unsigned t, l, b, r;
    if ($urandom_range(0, 4) == 0) begin
      query($urandom_range(0, 63), $urandom_range(0, 63),
            $urandom_range(0, 63), $urandom_range(0, 63));
    end else begin
      t = $urandom_range(0, h - 1);
      b = $urandom_range(t, h - 1);
      l = $urandom_range(0, w - 1);
      r = $urandom_range(l, w - 1);
      query(t, l, b, r);
    end
  endtask

  initial begin
    int unsigned raw_w, raw_h, raw_b, w, h, phase;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: a query on the reset setting before anything is loaded is flagged bad.
    query(0, 0, 63, 63);
    drain();
    // A single pixel image, width written as zero and bins written above the maximum.
    write_reg(REG_IMG_WIDTH, 7'd0);
    write_reg(REG_IMG_HEIGHT, 7'd1);
    write_reg(REG_BINS_IN_USE, 7'h3F);
    load_pixel(8'd255);
    query(0, 0, 0, 0);
    query(0, 0, 0, 1);
    query(1, 0, 0, 0);
    drain();
    // Two by two with a single bin (bins written as zero), then a restart by a fresh load.
    write_reg(REG_IMG_WIDTH, 7'd2);
    write_reg(REG_IMG_HEIGHT, 7'd2);
    write_reg(REG_BINS_IN_USE, 7'd0);
    load_pixel(8'd0);
    load_pixel(8'd255);
    load_pixel(8'd128);
    load_pixel(8'd1);
    query(0, 0, 1, 1);
    query(0, 1, 1, 0);
    query(1, 1, 1, 1);
    query(0, 0, 2, 1);
    load_pixel(8'd77);
    query(0, 0, 0, 0);
    drain();
    // An unused register index must leave the loaded state alone.
    write_reg(REG_BINS_IN_USE, 7'd16);
    load_image(4);
    drain();
    write_reg(2'd3, 7'h7F);
    query(0, 0, 1, 1);
    drain();

    // Random phases: each writes all three registers, loads a full image and asks windows.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        raw_w = 7'h7F; raw_h = 1; raw_b = 16;
      end else if (phase == 1) begin
        raw_w = 1; raw_h = 64; raw_b = $urandom_range(1, 16);
      end else begin
        raw_w = $urandom_range(1, 6);
        raw_h = $urandom_range(1, 6);
        raw_b = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
      end
      w = effective(raw_w);
      h = effective(raw_h);
      write_reg(REG_IMG_WIDTH, raw_w[6:0]);
      write_reg(REG_IMG_HEIGHT, raw_h[6:0]);
      write_reg(REG_BINS_IN_USE, raw_b[6:0]);
      if (items_sent > ITEM_TARGET - 40) calm = 1;
      if ($urandom_range(0, 3) == 0) random_window(w, h);
      load_image(w * h);
      // Phase 2 holds the receiver off while queries keep coming, phase 3 lets the
      // sender wait for every result before it goes on.
      if (phase == 2) hold_asked++;
      repeat ($urandom_range(4, 8)) random_window(w, h);
      if (phase == 3) begin
        in_push <= 0;
        while (pending != 0) @(negedge clk);
        random_window(w, h);
      end
      if ($urandom_range(0, 4) == 0) begin
        load_image($urandom_range(1, w * h));
        random_window(w, h);
      end
      drain();
      phase++;
    end

    if (fail_count == 0 && scoreboard.leftover() == 0) begin
      $display("integral_histogram_window_query regression: pass");
    end else begin
      $display("integral_histogram_window_query regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ihw_pkg.sv
sv/ihw_ram.sv
sv/ihw_fifo.sv
sv/ihw_front.sv
sv/ihw_back.sv
sv/integral_histogram_window_query.sv
dv/ihw_checker.sv
dv/testbench.sv
